// ----- rtl/brrc_pkg.sv -----
package brrc_pkg;

  // Field widths fixed by the request and result formats
  localparam int ACTION_W   = 2;
  localparam int OP_W       = 2;
  localparam int DEV_W      = 16;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = 9;
  localparam int CONSUMER_W = 6;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int SEG_OUT_W  = 4;
  localparam int LINK_W     = 2;

  // Buffers must sit on a 512-byte boundary
  localparam logic [WORD_W-1:0] ALIGN_MASK = WORD_W'((1 << CNT_W) - 1);

  // Default geometry of the ring
  localparam int DEF_RING_ENTRIES = 64;
  localparam int DEF_MAX_SEGMENTS = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SUBMIT   = 2'd0,
    ACT_PUBLISH  = 2'd1,
    ACT_CONSUMER = 2'd2
  } action_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [LINK_W-1:0] {
    LINK_ACTIVE    = 2'd0,
    LINK_SUSPENDED = 2'd1,
    LINK_CLOSED    = 2'd2
  } link_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 3'd0,
    ST_MERGED    = 3'd1,
    ST_PLUGGED   = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_BAD       = 3'd4,
    ST_PUBLISHED = 3'd5,
    ST_CONSUMER  = 3'd6
  } status_t;

  // Request after the first stage: absolute sector and alignment resolved
  typedef struct packed {
    action_t                 action;
    op_t                     op_kind;
    logic [DEV_W-1:0]        device_id;
    logic [WORD_W-1:0]       sector;
    logic                    misaligned;
    logic [WORD_W-1:0]       buffer_addr;
    logic [CNT_W-1:0]        sector_count;
    logic [WORD_W-1:0]       tag;
    logic [CONSUMER_W-1:0]   new_consumer;
  } dec_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic [SEG_OUT_W-1:0]    segment_index;
    logic [WORD_W-1:0]       segment_word;
    logic [WORD_W-1:0]       abs_sector;
    logic [OP_W-1:0]         op_out;
    logic [DEV_W-1:0]        device_out;
    logic [WORD_W-1:0]       tag_out;
    logic [WORD_W-1:0]       previous_tag;
    logic [SLOT_OUT_W-1:0]   producer_index;
    logic                    below_half;
  } rsp_t;

endpackage

// ----- rtl/brrc_req_if.sv -----
interface brrc_req_if
  import brrc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [OP_W-1:0]       op_kind;
  logic [DEV_W-1:0]      device_id;
  logic [WORD_W-1:0]     rel_sector;
  logic [WORD_W-1:0]     part_start;
  logic [WORD_W-1:0]     buffer_addr;
  logic [CNT_W-1:0]      sector_count;
  logic [WORD_W-1:0]     tag;
  logic [CONSUMER_W-1:0] new_consumer;

  modport source (
    output valid, action, op_kind, device_id, rel_sector, part_start,
           buffer_addr, sector_count, tag, new_consumer,
    input  ready
  );

  modport sink (
    input  valid, action, op_kind, device_id, rel_sector, part_start,
           buffer_addr, sector_count, tag, new_consumer,
    output ready
  );
endinterface

// ----- rtl/brrc_rsp_if.sv -----
interface brrc_rsp_if
  import brrc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [SEG_OUT_W-1:0]  segment_index;
  logic [WORD_W-1:0]     segment_word;
  logic [WORD_W-1:0]     abs_sector;
  logic [OP_W-1:0]       op_out;
  logic [DEV_W-1:0]      device_out;
  logic [WORD_W-1:0]     tag_out;
  logic [WORD_W-1:0]     previous_tag;
  logic [SLOT_OUT_W-1:0] producer_index;
  logic                  below_half;

  modport source (
    output valid, status, slot_index, segment_index, segment_word, abs_sector,
           op_out, device_out, tag_out, previous_tag, producer_index, below_half,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, segment_index, segment_word, abs_sector,
           op_out, device_out, tag_out, previous_tag, producer_index, below_half,
    output ready
  );
endinterface

// ----- rtl/brrc_in_stage.sv -----
module brrc_in_stage
  import brrc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  brrc_req_if.sink        req,
  output logic            dec_valid,
  input  logic            dec_ready,
  output dec_t            dec
);

  logic load;

  // Take a new beat when empty or when the core drains this one
  assign req.ready = !dec_valid || dec_ready;
  assign load      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (req.ready) begin
      dec_valid <= req.valid;
    end
  end

  // Resolve the absolute sector and the alignment check up front
  always_ff @(posedge clk) begin
    if (load) begin
      dec.action       <= action_t'(req.action);
      dec.op_kind      <= op_t'(req.op_kind);
      dec.device_id    <= req.device_id;
      dec.sector       <= req.rel_sector + req.part_start;
      dec.misaligned   <= |(req.buffer_addr & ALIGN_MASK);
      dec.buffer_addr  <= req.buffer_addr;
      dec.sector_count <= req.sector_count;
      dec.tag          <= req.tag;
      dec.new_consumer <= req.new_consumer;
    end
  end

endmodule

// ----- rtl/brrc_core.sv -----
module brrc_core
  import brrc_pkg::*;
#(
  parameter int RING_ENTRIES = DEF_RING_ENTRIES,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LINK_W-1:0] cfg_wdata,
  input  logic              dec_valid,
  output logic              dec_ready,
  input  dec_t              dec,
  brrc_rsp_if.source        rsp
);

  localparam int IW         = $clog2(RING_ENTRIES);
  localparam int SW         = $clog2(MAX_SEGMENTS + 1);
  localparam int CONS_SPAN  = 1 << CONSUMER_W;

  // Link mode and ring state
  link_t             link_mode;
  logic [IW-1:0]     producer_idx, producer_idx_next;
  logic [IW-1:0]     consumer_idx, consumer_idx_next;
  logic              merge_open, merge_open_next;
  logic              merge_write, merge_write_next;
  logic [DEV_W-1:0]  merge_device, merge_device_next;
  logic [WORD_W-1:0] merge_next_sector, merge_next_sector_next;
  logic [WORD_W-1:0] last_tag, last_tag_next;
  logic [SW-1:0]     last_segments, last_segments_next;

  // Result register
  logic              out_valid;
  rsp_t              res, res_next;

  logic              fire;
  logic [IW-1:0]     prod_inc;
  logic [IW-1:0]     prod_prev;
  logic              plugged;
  logic              continues;
  logic              open_new;
  logic [SW-1:0]     seg_inc;
  logic [IW:0]       span_raw;
  logic [IW-1:0]     span;
  logic [WORD_W-1:0] seg_word;
  logic [IW-1:0]     cons_tbl [CONS_SPAN];

  // Reduce the consumer index into the ring, one entry per code
  for (genvar g = 0; g < CONS_SPAN; g++) begin : g_cons
    assign cons_tbl[g] = IW'(g % RING_ENTRIES);
  end

  assign dec_ready = !out_valid || rsp.ready;
  assign fire      = dec_valid && dec_ready;

  assign prod_inc  = (producer_idx == IW'(RING_ENTRIES - 1)) ? '0 : producer_idx + 1'b1;
  assign prod_prev = (producer_idx == '0) ? IW'(RING_ENTRIES - 1) : producer_idx - 1'b1;
  assign plugged   = (prod_inc == consumer_idx) || (link_mode != LINK_ACTIVE);
  assign continues = merge_open && (merge_write == dec.op_kind[0]) &&
                     (merge_device == dec.device_id) &&
                     (merge_next_sector == dec.sector);
  assign seg_inc   = last_segments + 1'b1;
  assign seg_word  = dec.buffer_addr | WORD_W'(dec.sector_count);

  // Decide the beat and form the next state and result
  always_comb begin
    producer_idx_next      = producer_idx;
    consumer_idx_next      = consumer_idx;
    merge_open_next        = merge_open;
    merge_write_next       = merge_write;
    merge_device_next      = merge_device;
    merge_next_sector_next = merge_next_sector;
    last_tag_next          = last_tag;
    last_segments_next     = last_segments;
    open_new               = 1'b0;
    res_next               = '0;
    res_next.status        = ST_BAD;

    unique case (dec.action)
      ACT_PUBLISH: begin
        merge_open_next = 1'b0;
        res_next.status = ST_PUBLISHED;
      end
      ACT_CONSUMER: begin
        consumer_idx_next = cons_tbl[dec.new_consumer];
        res_next.status   = ST_CONSUMER;
      end
      ACT_SUBMIT: begin
        priority if (dec.misaligned) begin
          res_next.status = ST_BAD;
        end else if (link_mode == LINK_CLOSED) begin
          res_next.status = ST_CLOSED;
        end else if (dec.op_kind == OP_PROBE) begin
          if (plugged) begin
            res_next.status = ST_PLUGGED;
          end else begin
            merge_open_next = 1'b0;
            open_new        = 1'b1;
          end
        end else if (dec.op_kind == OP_READ || dec.op_kind == OP_WRITE) begin
          priority if (continues) begin
            // Append one more segment to the last descriptor
            res_next.status        = ST_MERGED;
            res_next.slot_index    = SLOT_OUT_W'(prod_prev);
            res_next.segment_index = SEG_OUT_W'(last_segments);
            res_next.segment_word  = seg_word;
            res_next.tag_out       = dec.tag;
            res_next.previous_tag  = last_tag;
            last_tag_next          = dec.tag;
            last_segments_next     = seg_inc;
            if (seg_inc < SW'(MAX_SEGMENTS)) begin
              merge_next_sector_next = merge_next_sector + WORD_W'(dec.sector_count);
            end else begin
              merge_open_next = 1'b0;
            end
          end else if (plugged) begin
            res_next.status = ST_PLUGGED;
          end else begin
            merge_open_next        = 1'b1;
            merge_write_next       = dec.op_kind[0];
            merge_device_next      = dec.device_id;
            merge_next_sector_next = dec.sector + WORD_W'(dec.sector_count);
            open_new               = 1'b1;
          end
        end else begin
          res_next.status = ST_BAD;
        end
      end
      default: begin
        res_next.status = ST_BAD;
      end
    endcase

    // Open a fresh descriptor at the producer slot
    if (open_new) begin
      res_next.status       = ST_NEW;
      res_next.slot_index   = SLOT_OUT_W'(producer_idx);
      res_next.segment_word = seg_word;
      res_next.abs_sector   = (dec.op_kind == OP_PROBE) ? '0 : dec.sector;
      res_next.op_out       = dec.op_kind;
      res_next.device_out   = dec.device_id;
      res_next.tag_out      = dec.tag;
      last_tag_next         = dec.tag;
      last_segments_next    = SW'(1);
      producer_idx_next     = prod_inc;
    end

    res_next.producer_index = SLOT_OUT_W'(producer_idx_next);

    // Outstanding distance after this beat
    span_raw = {1'b0, producer_idx_next} - {1'b0, consumer_idx_next};
    span     = span_raw[IW-1:0] + (span_raw[IW] ? IW'(RING_ENTRIES) : '0);
    res_next.below_half = (span < IW'(RING_ENTRIES / 2));
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode         <= LINK_SUSPENDED;
      producer_idx      <= '0;
      consumer_idx      <= '0;
      merge_open        <= 1'b0;
      merge_write       <= 1'b0;
      merge_device      <= '0;
      merge_next_sector <= '0;
      last_tag          <= '0;
      last_segments     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        link_mode <= link_t'(cfg_wdata);
      end
      if (fire) begin
        producer_idx      <= producer_idx_next;
        consumer_idx      <= consumer_idx_next;
        merge_open        <= merge_open_next;
        merge_write       <= merge_write_next;
        merge_device      <= merge_device_next;
        merge_next_sector <= merge_next_sector_next;
        last_tag          <= last_tag_next;
        last_segments     <= last_segments_next;
      end
      if (dec_ready) begin
        out_valid <= dec_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = res.status;
  assign rsp.slot_index     = res.slot_index;
  assign rsp.segment_index  = res.segment_index;
  assign rsp.segment_word   = res.segment_word;
  assign rsp.abs_sector     = res.abs_sector;
  assign rsp.op_out         = res.op_out;
  assign rsp.device_out     = res.device_out;
  assign rsp.tag_out        = res.tag_out;
  assign rsp.previous_tag   = res.previous_tag;
  assign rsp.producer_index = res.producer_index;
  assign rsp.below_half     = res.below_half;

  // An open run always has room for one more segment
  a_open_run_room: assert property (@(posedge clk) disable iff (rst)
    merge_open |-> (last_segments != '0) && (last_segments < SW'(MAX_SEGMENTS)))
    else $error("open run with segment count out of range");

  // Ring indices stay inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (producer_idx < IW'(RING_ENTRIES - 1) || producer_idx == IW'(RING_ENTRIES - 1)) &&
    (consumer_idx < IW'(RING_ENTRIES - 1) || consumer_idx == IW'(RING_ENTRIES - 1)))
    else $error("ring index beyond ring size");

  // Only a new descriptor moves the producer
  a_prod_only_on_new: assert property (@(posedge clk) disable iff (rst)
    fire && (res_next.status != ST_NEW) |=> $stable(producer_idx))
    else $error("producer index moved without a new descriptor");

endmodule

// ----- rtl/block_request_ring_coalescer.sv -----
// Producer side of a block request descriptor ring with segment merging.
// Channel req carries one request beat: submit, publish or consumer update.
// Channel rsp returns exactly one result beat per request, in order: the
// status, the ring slot and segment written, the descriptor fields, and the
// producer index and half-full flag after the request.
// Write cfg_we / cfg_wdata to set the link mode (active, suspended, closed)
// while no request is in flight.
// The edge that accepts a request loads the input register; the core loads the
// result register from it when it takes the beat, and the result is offered
// from the result register. Throughput: one request per cycle while rsp does
// not stall; the merge check, the ring full test and the index update are all
// combinational between the input register and the result register.
// Reset leaves the link suspended, both ring indices at zero and no open run.
// When rsp stalls, the result register holds, the input register fills and
// req.ready drops; up to two requests sit inside the block.
module block_request_ring_coalescer
  import brrc_pkg::*;
#(
  parameter int RING_ENTRIES = DEF_RING_ENTRIES,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LINK_W-1:0] cfg_wdata,
  brrc_req_if.sink          req,
  brrc_rsp_if.source        rsp
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec;

  // Register the request and resolve its sector
  brrc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  // Merge decision, ring state and result register
  brrc_core #(
    .RING_ENTRIES (RING_ENTRIES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .rsp       (rsp)
  );

endmodule
